// ===== hdl/obst_pkg.sv =====
// Package: constants and types shared by the optimal BST cost block.
package obst_pkg;
  localparam int MaxKeys = 64;
  localparam int FreqBits = 16;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = $clog2(MaxKeys + 1);
  localparam int AddrW = 2 * IdxW;
  localparam logic [31:0] CostMax = 32'hFFFF_FFFF;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic store;
    logic fill_init;
    logic diag_rd;
    logic diag_wr;
    logic row_rd;
    logic row_take;
    logic read_bounds;
    logic take_bounds;
    logic read_k;
    logic eval_k;
    logic write_cell;
    logic read_final;
    logic clear_set;
  } cmd_t;

  typedef struct packed {
    logic diag_done;
    logic k_done;
    logic j_done;
    logic i_done;
    logic empty;
  } sts_t;
endpackage

// ===== hdl/obst_if.sv =====
// Interfaces: valid/ready channels for input and result items.
interface obst_in_if;
  logic valid;
  logic ready;
  logic [15:0] frequency;
  logic last;
  modport source (output valid, frequency, last, input ready);
  modport sink (input valid, frequency, last, output ready);
endinterface

interface obst_out_if;
  logic valid;
  logic ready;
  logic [31:0] total_cost;
  logic [5:0] root_index;
  logic [6:0] key_count;
  logic [1:0] status;
  modport source (output valid, total_cost, root_index, key_count, status, input ready);
  modport sink (input valid, total_cost, root_index, key_count, status, output ready);
endinterface

// ===== hdl/obst_datapath.sv =====
// Datapath: frequency store, cost and root tables, interval loop counters.
module obst_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  obst_pkg::cmd_t               cmd_i,
  output obst_pkg::sts_t               sts_o,
  input  logic [15:0]                  frequency_i,
  output logic [31:0]                  total_cost_o,
  output logic [5:0]                   root_index_o,
  output logic [6:0]                   key_count_o,
  output logic [1:0]                   status_o
);
  localparam int IdxW = obst_pkg::IdxW;
  localparam int CntW = obst_pkg::CntW;
  localparam int AddrW = obst_pkg::AddrW;

  logic [obst_pkg::FreqBits-1:0] freq_mem [obst_pkg::MaxKeys];
  logic [31:0] cost_mem [obst_pkg::MaxKeys * obst_pkg::MaxKeys];
  logic [IdxW-1:0] root_mem [obst_pkg::MaxKeys * obst_pkg::MaxKeys];

  logic [CntW-1:0] cnt_q;
  logic ovf_q;
  logic [IdxW-1:0] i_q, j_q, k_q, hi_q, best_root_q;
  logic [33:0] best_q;
  logic [33:0] weight_q;
  logic [obst_pkg::FreqBits-1:0] freq_rd_q;
  logic [31:0] costa_q, costb_q;
  logic [IdxW-1:0] roota_q, rootb_q;
  logic [IdxW-1:0] n1;
  logic [AddrW-1:0] addr_a, addr_b, addr_w;
  logic [31:0] wdata;
  logic [IdxW-1:0] wroot;
  logic [IdxW-1:0] freq_addr;
  logic freq_rd_en, mem_rd_en, wr_en;
  logic [IdxW-1:0] lo_c, hi_c;
  logic [33:0] left_c, right_c, total_c;

  assign n1 = IdxW'(cnt_q - CntW'(1));

  // read addresses per phase
  always_comb begin
    addr_a = {i_q, j_q};
    addr_b = {i_q, j_q};
    if (cmd_i.read_bounds) begin
      addr_a = {i_q, IdxW'(j_q - IdxW'(1))};
      addr_b = {IdxW'(i_q + IdxW'(1)), j_q};
    end else if (cmd_i.read_k) begin
      addr_a = {i_q, IdxW'(k_q - IdxW'(1))};
      addr_b = {IdxW'(k_q + IdxW'(1)), j_q};
    end else if (cmd_i.read_final) begin
      addr_a = {IdxW'(0), n1};
    end
  end

  assign freq_addr = cmd_i.read_bounds ? j_q : i_q;
  assign freq_rd_en = cmd_i.diag_rd || cmd_i.row_rd || cmd_i.read_bounds;
  assign mem_rd_en = cmd_i.read_bounds || cmd_i.read_k || cmd_i.read_final;
  assign wr_en = cmd_i.diag_wr || cmd_i.write_cell;

  assign lo_c = (roota_q < i_q) ? i_q : roota_q;
  always_comb begin
    hi_c = (rootb_q > j_q) ? j_q : rootb_q;
    if (hi_c < lo_c) hi_c = lo_c;
  end
  assign left_c = (k_q > i_q) ? {2'b0, costa_q} : 34'd0;
  assign right_c = (k_q < j_q) ? {2'b0, costb_q} : 34'd0;
  assign total_c = left_c + right_c + weight_q;

  always_comb begin
    addr_w = {i_q, i_q};
    wdata = 32'(freq_rd_q);
    wroot = i_q;
    if (cmd_i.write_cell) begin
      addr_w = {i_q, j_q};
      wdata = (best_q > 34'(obst_pkg::CostMax)) ? obst_pkg::CostMax : best_q[31:0];
      wroot = best_root_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !cnt_q[CntW-1]) begin
      freq_mem[cnt_q[IdxW-1:0]] <= frequency_i[obst_pkg::FreqBits-1:0];
    end
    if (freq_rd_en) freq_rd_q <= freq_mem[freq_addr];
    if (mem_rd_en) begin
      costa_q <= cost_mem[addr_a];
      costb_q <= cost_mem[addr_b];
      roota_q <= root_mem[addr_a];
      rootb_q <= root_mem[addr_b];
    end
    if (wr_en) begin
      cost_mem[addr_w] <= wdata;
      root_mem[addr_w] <= wroot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      hi_q <= '0;
      best_root_q <= '0;
      best_q <= '0;
      weight_q <= '0;
    end else begin
      if (cmd_i.store) begin
        if (cnt_q[CntW-1]) ovf_q <= 1'b1;
        else cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.clear_set) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.fill_init) begin
        i_q <= '0;
      end
      if (cmd_i.diag_wr) begin
        i_q <= (i_q == n1) ? IdxW'(n1 - IdxW'(1)) : IdxW'(i_q + IdxW'(1));
      end
      if (cmd_i.row_take) begin
        weight_q <= 34'(freq_rd_q);
        j_q <= i_q + IdxW'(1);
      end
      if (cmd_i.take_bounds) begin
        weight_q <= weight_q + 34'(freq_rd_q);
        k_q <= lo_c;
        hi_q <= hi_c;
        best_root_q <= lo_c;
        best_q <= '1;
      end
      if (cmd_i.eval_k) begin
        if (total_c < best_q) begin
          best_q <= total_c;
          best_root_q <= k_q;
        end
        k_q <= k_q + IdxW'(1);
      end
      if (cmd_i.write_cell) begin
        if (j_q == n1) begin
          i_q <= i_q - IdxW'(1);
        end else begin
          j_q <= j_q + IdxW'(1);
        end
      end
    end
  end

  assign sts_o.diag_done = (i_q == n1);
  assign sts_o.k_done = (k_q == hi_q);
  assign sts_o.j_done = (j_q == n1);
  assign sts_o.i_done = (i_q == '0);
  assign sts_o.empty = (cnt_q == '0);

  assign total_cost_o = sts_o.empty ? 32'd0 : costa_q;
  assign root_index_o = sts_o.empty ? 6'd0 : 6'(roota_q);
  assign key_count_o = 7'(cnt_q);
  assign status_o = sts_o.empty ? obst_pkg::StatusEmpty :
                    (ovf_q ? obst_pkg::StatusOverflow : obst_pkg::StatusOk);
endmodule

// ===== hdl/obst_ctrl.sv =====
// Controller: sequences load, table fill, result hand-off.
module obst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  obst_pkg::sts_t sts_i,
  output obst_pkg::cmd_t cmd_o
);
  localparam logic [3:0] SLoad = 4'd0;
  localparam logic [3:0] SWait = 4'd1;
  localparam logic [3:0] SDiagRd = 4'd2;
  localparam logic [3:0] SDiagWr = 4'd3;
  localparam logic [3:0] SRowRd = 4'd4;
  localparam logic [3:0] SRowTk = 4'd5;
  localparam logic [3:0] SCellRd = 4'd6;
  localparam logic [3:0] SBndTk = 4'd7;
  localparam logic [3:0] SKRd = 4'd8;
  localparam logic [3:0] SKEv = 4'd9;
  localparam logic [3:0] SWrite = 4'd10;
  localparam logic [3:0] SFinRd = 4'd11;
  localparam logic [3:0] SOut = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == SLoad);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      SLoad: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (in_last_i) state_d = SWait;
        end
      end
      SWait: begin
        if (sts_i.empty) state_d = SFinRd;
        else begin
          cmd_o.fill_init = 1'b1;
          state_d = SDiagRd;
        end
      end
      SDiagRd: begin
        cmd_o.diag_rd = 1'b1;
        state_d = SDiagWr;
      end
      SDiagWr: begin
        cmd_o.diag_wr = 1'b1;
        if (sts_i.diag_done) state_d = sts_i.i_done ? SFinRd : SRowRd;
        else state_d = SDiagRd;
      end
      SRowRd: begin
        cmd_o.row_rd = 1'b1;
        state_d = SRowTk;
      end
      SRowTk: begin
        cmd_o.row_take = 1'b1;
        state_d = SCellRd;
      end
      SCellRd: begin
        cmd_o.read_bounds = 1'b1;
        state_d = SBndTk;
      end
      SBndTk: begin
        cmd_o.take_bounds = 1'b1;
        state_d = SKRd;
      end
      SKRd: begin
        cmd_o.read_k = 1'b1;
        state_d = SKEv;
      end
      SKEv: begin
        cmd_o.eval_k = 1'b1;
        state_d = sts_i.k_done ? SWrite : SKRd;
      end
      SWrite: begin
        cmd_o.write_cell = 1'b1;
        if (sts_i.j_done) state_d = sts_i.i_done ? SFinRd : SRowRd;
        else state_d = SCellRd;
      end
      SFinRd: begin
        cmd_o.read_final = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) begin
          cmd_o.clear_set = 1'b1;
          state_d = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o));
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o);
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o);
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= SOut);
`endif
endmodule

// ===== hdl/optimal_bst_cost.sv =====
// Optimal BST cost: loads frequencies at one item per cycle while in ready is high. After the
// item marked last, ready drops and the block fills the interval tables with Knuth's root
// bound: a start step, the diagonal key by key, then each of the n-1 rows, where each interval
// reads its bounds and evaluates each root candidate in the bound window, then a read of the
// final cell; with no key loaded it skips the fill. The result is held until taken, and ready
// returns the cycle after. Keys beyond capacity are dropped and flagged in the status.
module optimal_bst_cost (
  input  logic clk_i,
  input  logic rst_ni,
  obst_in_if.sink    in_if,
  obst_out_if.source out_if
);
  obst_pkg::cmd_t cmd;
  obst_pkg::sts_t sts;

  obst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_last_i(in_if.last), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  obst_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .frequency_i(in_if.frequency),
    .total_cost_o(out_if.total_cost), .root_index_o(out_if.root_index),
    .key_count_o(out_if.key_count), .status_o(out_if.status)
  );
endmodule
